>>> sv/gpsp_pkg.sv
// Shared types and constants for the gamepad serial poll master.
// No dependencies; imported by gpsp_decoder and gamepad_serial_poll_master.
package gpsp_pkg;

  localparam int FRAME_BYTES_DEF = 9;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_H_CENTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V_CENTER = 2'd3;

  localparam logic [7:0] POLL_CMD_RST = 8'h42;
  localparam logic [7:0] ANALOG_ID_RST = 8'h73;
  localparam logic [7:0] H_CENTER_RST = 8'd128;
  localparam logic [7:0] V_CENTER_RST = 8'd127;

  localparam logic [7:0] START_BYTE = 8'h01;

  localparam logic [1:0] PH_LOW = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_GAP = 2'd2;

  // decode steps, one received byte each
  localparam logic [2:0] ST_MODE = 3'd0;
  localparam logic [2:0] ST_BTN_LO = 3'd1;
  localparam logic [2:0] ST_BTN_HI = 3'd2;
  localparam logic [2:0] ST_RH = 3'd3;
  localparam logic [2:0] ST_RV = 3'd4;
  localparam logic [2:0] ST_LH = 3'd5;
  localparam logic [2:0] ST_LV = 3'd6;
  localparam logic [2:0] DEC_STEPS = 3'd7;
  localparam logic [3:0] BYTE_MODE = 4'd1;

  typedef struct packed {
    logic [7:0] poll_cmd;
    logic [7:0] analog_id;
    logic [7:0] h_center;
    logic [7:0] v_center;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0]        mode;
    logic [15:0]       buttons;
    logic signed [8:0] rh;
    logic signed [8:0] rv;
    logic signed [8:0] lh;
    logic signed [8:0] lv;
  } decoded_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dec_status_t;

endpackage

>>> sv/gpsp_decoder.sv
// Received-byte memory and end-of-frame decode sequencer.
// Depends on gpsp_pkg.
module gpsp_decoder
  import gpsp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_regs_t     cfg,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          start,
  input  logic          ack,
  output dec_status_t   status,
  output decoded_t      decoded
);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN = 2'd1;
  localparam logic [1:0] DS_WAIT = 2'd2;

  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rd_r;
  logic [AW-1:0] rd_addr;
  logic [1:0]    state_r;
  logic [2:0]    cnt_r;
  logic [2:0]    step;
  logic          analog_r;
  decoded_t      dec_r;
  logic signed [8:0] h_val;
  logic signed [8:0] v_val;
  logic signed [8:0] raw_val;

  always_comb begin
    if (cnt_r == ST_MODE || cnt_r == DEC_STEPS) begin
      rd_addr = AW'(BYTE_MODE);
    end else begin
      rd_addr = AW'({1'b0, cnt_r} + 4'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign step = cnt_r - 3'd1;
  assign raw_val = $signed({1'b0, rd_r});
  assign h_val = analog_r ? $signed({1'b0, rd_r} - {1'b0, cfg.h_center}) : raw_val;
  assign v_val = analog_r ? $signed({1'b0, cfg.v_center} - {1'b0, rd_r}) : raw_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      cnt_r <= '0;
      analog_r <= 1'b0;
      dec_r <= '0;
    end else begin
      unique case (state_r)
        DS_RUN: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r != ST_MODE) begin
            unique case (step)
              ST_MODE: begin
                dec_r.mode <= rd_r;
                analog_r <= (rd_r == cfg.analog_id);
              end
              ST_BTN_LO: dec_r.buttons[7:0] <= ~rd_r;
              ST_BTN_HI: dec_r.buttons[15:8] <= ~rd_r;
              ST_RH: dec_r.rh <= h_val;
              ST_RV: dec_r.rv <= v_val;
              ST_LH: dec_r.lh <= h_val;
              ST_LV: dec_r.lv <= v_val;
              default: ;
            endcase
          end
          if (cnt_r == DEC_STEPS) begin
            state_r <= DS_WAIT;
          end
        end
        DS_WAIT: begin
          if (ack) begin
            state_r <= DS_IDLE;
          end
        end
        default: begin
          if (start) begin
            state_r <= DS_RUN;
            cnt_r <= '0;
          end
        end
      endcase
    end
  end

  assign status.busy = (state_r != DS_IDLE);
  assign status.done = (state_r == DS_WAIT);
  assign decoded = dec_r;

endmodule

>>> sv/gamepad_serial_poll_master.sv
// Top level of the gamepad serial poll master: tick handshake, bit/byte sequencer,
// configuration registers and output word register. Depends on gpsp_pkg, gpsp_decoder.
//
// Each input word is one link tick and produces exactly one output word. Ticks are
// taken one per clock while the output register is free or being drained and no
// decode pass is running; every tick but one is registered straight into the output
// register. The exception is the tick that closes a frame (last gap tick). It starts a
// decode pass over the received-byte memory: seven reads of the single read port,
// each decoded from the registered read data in the cycle after it. The result is then
// handed to the output register once that register is free. No new tick is taken until
// the result has been handed over.
module gamepad_serial_poll_master
  import gpsp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_start_req,
  input  logic                 in_data_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_clk_out,
  output logic                 out_cmd_out,
  output logic                 out_select_n,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic [7:0]           out_mode_id,
  output logic [15:0]          out_buttons,
  output logic signed [8:0]    out_right_horizontal,
  output logic signed [8:0]    out_right_vertical,
  output logic signed [8:0]    out_left_horizontal,
  output logic signed [8:0]    out_left_vertical
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int BW = $clog2(FRAME_BYTES + 1);

  cfg_regs_t   cfg_r;
  logic        active_r, active_nxt;
  logic [BW-1:0] byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        clk_lvl_r, clk_lvl_nxt;
  logic        cmd_lvl_r, cmd_lvl_nxt;
  logic        out_valid_r;
  logic        last_tick;
  logic        byte_done;
  logic        send_bit;
  logic        accept;
  logic        slot_free;
  logic        ack;
  dec_status_t dec_status;
  decoded_t    decoded;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = !dec_status.busy && slot_free;
  assign accept = in_valid && in_ready;
  assign ack = dec_status.done && slot_free;

  always_comb begin
    if (byte_r == BW'(0)) begin
      send_bit = (bit_r == 3'd0) ? START_BYTE[0] : 1'b0;
    end else if (byte_r == BW'(1)) begin
      send_bit = cfg_r.poll_cmd[bit_r];
    end else begin
      send_bit = 1'b0;
    end
  end

  always_comb begin
    active_nxt = active_r;
    byte_nxt = byte_r;
    bit_nxt = bit_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    clk_lvl_nxt = clk_lvl_r;
    cmd_lvl_nxt = cmd_lvl_r;
    last_tick = 1'b0;
    byte_done = 1'b0;
    if (!active_r) begin
      if (in_start_req) begin
        active_nxt = 1'b1;
        byte_nxt = '0;
        bit_nxt = '0;
        phase_nxt = PH_LOW;
        shift_nxt = '0;
      end
    end else begin
      unique case (phase_r)
        PH_HIGH: begin
          clk_lvl_nxt = 1'b1;
          shift_nxt = shift_r | (8'(in_data_in) << bit_r);
          if (bit_r == 3'd7) begin
            byte_done = 1'b1;
            phase_nxt = PH_GAP;
          end else begin
            bit_nxt = bit_r + 3'd1;
            phase_nxt = PH_LOW;
          end
        end
        PH_GAP: begin
          clk_lvl_nxt = 1'b1;
          cmd_lvl_nxt = 1'b1;
          bit_nxt = '0;
          shift_nxt = '0;
          phase_nxt = PH_LOW;
          if (byte_r == BW'(FRAME_BYTES - 1)) begin
            active_nxt = 1'b0;
            byte_nxt = '0;
            last_tick = 1'b1;
          end else begin
            byte_nxt = BW'(byte_r + 1'b1);
          end
        end
        default: begin
          clk_lvl_nxt = 1'b0;
          cmd_lvl_nxt = send_bit;
          phase_nxt = PH_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{POLL_CMD_RST, ANALOG_ID_RST, H_CENTER_RST, V_CENTER_RST};
      active_r <= 1'b0;
      byte_r <= '0;
      bit_r <= '0;
      phase_r <= PH_LOW;
      shift_r <= '0;
      clk_lvl_r <= 1'b0;
      cmd_lvl_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLL_CMD: cfg_r.poll_cmd <= cfg_wdata;
          CFG_ANALOG_ID: cfg_r.analog_id <= cfg_wdata;
          CFG_H_CENTER: cfg_r.h_center <= cfg_wdata;
          CFG_V_CENTER: cfg_r.v_center <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        active_r <= active_nxt;
        byte_r <= byte_nxt;
        bit_r <= bit_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        clk_lvl_r <= clk_lvl_nxt;
        cmd_lvl_r <= cmd_lvl_nxt;
      end
      if ((accept && !last_tick) || ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_tick) begin
      out_clk_out <= clk_lvl_nxt;
      out_cmd_out <= cmd_lvl_nxt;
      out_select_n <= !active_nxt;
      out_busy_res <= active_nxt;
      out_frame_done <= 1'b0;
      out_mode_id <= decoded.mode;
      out_buttons <= decoded.buttons;
      out_right_horizontal <= decoded.rh;
      out_right_vertical <= decoded.rv;
      out_left_horizontal <= decoded.lh;
      out_left_vertical <= decoded.lv;
    end else if (ack) begin
      out_clk_out <= clk_lvl_r;
      out_cmd_out <= cmd_lvl_r;
      out_select_n <= 1'b1;
      out_busy_res <= 1'b0;
      out_frame_done <= 1'b1;
      out_mode_id <= decoded.mode;
      out_buttons <= decoded.buttons;
      out_right_horizontal <= decoded.rh;
      out_right_vertical <= decoded.rv;
      out_left_horizontal <= decoded.lh;
      out_left_vertical <= decoded.lv;
    end
  end

  assign out_valid = out_valid_r;

  gpsp_decoder #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .wr_en   (accept && byte_done),
    .wr_addr (byte_r[AW-1:0]),
    .wr_data (shift_nxt),
    .start   (accept && last_tick),
    .ack     (ack),
    .status  (dec_status),
    .decoded (decoded)
  );

endmodule

>>> test/tb_gamepad_serial_poll_master.sv
// Testbench for gamepad_serial_poll_master: drives link ticks, predicts every output word
// and checks it. Depends on gpsp_pkg and the gamepad_serial_poll_master RTL only.
module tb_gamepad_serial_poll_master;
  import gpsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN = FRAME_BYTES_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       clk_l;
    logic       cmd_l;
    logic       sel_n;
    logic       busy;
    logic       done;
    logic [7:0] mode;
    logic [15:0] buttons;
    logic [8:0] rh;
    logic [8:0] rv;
    logic [8:0] lh;
    logic [8:0] lv;
  } link_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic in_start_req;
  logic in_data_in;
  logic out_valid;
  logic out_ready;
  logic out_clk_out;
  logic out_cmd_out;
  logic out_select_n;
  logic out_busy_res;
  logic out_frame_done;
  logic [7:0] out_mode_id;
  logic [15:0] out_buttons;
  logic signed [8:0] out_right_horizontal;
  logic signed [8:0] out_right_vertical;
  logic signed [8:0] out_left_horizontal;
  logic signed [8:0] out_left_vertical;

  gamepad_serial_poll_master dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_req        (in_start_req),
    .in_data_in          (in_data_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_clk_out         (out_clk_out),
    .out_cmd_out         (out_cmd_out),
    .out_select_n        (out_select_n),
    .out_busy_res        (out_busy_res),
    .out_frame_done      (out_frame_done),
    .out_mode_id         (out_mode_id),
    .out_buttons         (out_buttons),
    .out_right_horizontal(out_right_horizontal),
    .out_right_vertical  (out_right_vertical),
    .out_left_horizontal (out_left_horizontal),
    .out_left_vertical   (out_left_vertical)
  );

  // link model state and register mirror
  logic [7:0] cfg_poll, cfg_analog, cfg_hctr, cfg_vctr;
  logic       lk_active;
  logic [4:0] lk_byte;
  logic [2:0] lk_bit;
  logic [1:0] lk_phase;
  logic [7:0] lk_shift;
  logic [7:0] rx_bytes [FRAME_LEN];
  logic       lk_clk, lk_cmd;
  logic [7:0] dec_mode;
  logic [15:0] dec_buttons;
  logic [8:0] dec_rh, dec_rv, dec_lh, dec_lv;

  link_word_t expected_words [$];
  link_word_t exp_w, got_w;

  int  fail_count;
  int  mismatch_count;
  int  ticks_sent;
  int  hold_reqs;
  int  idle_cycles;
  bit  tx_idle_on;
  bit  rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic reset_model();
    cfg_poll = POLL_CMD_RST;
    cfg_analog = ANALOG_ID_RST;
    cfg_hctr = H_CENTER_RST;
    cfg_vctr = V_CENTER_RST;
    lk_active = 1'b0;
    lk_byte = '0;
    lk_bit = '0;
    lk_phase = PH_LOW;
    lk_shift = '0;
    for (int i = 0; i < FRAME_LEN; i++) rx_bytes[i] = '0;
    lk_clk = 1'b0;
    lk_cmd = 1'b0;
    dec_mode = '0;
    dec_buttons = '0;
    dec_rh = '0;
    dec_rv = '0;
    dec_lh = '0;
    dec_lv = '0;
  endtask

  task automatic predict_tick(input bit s, input bit d);
    link_word_t w;
    logic [7:0] tx;
    bit done;
    done = 1'b0;
    if (!lk_active) begin
      if (s) begin
        lk_active = 1'b1;
        lk_byte = '0;
        lk_bit = '0;
        lk_phase = PH_LOW;
        lk_shift = '0;
      end
    end else if (lk_phase == PH_HIGH) begin
      lk_clk = 1'b1;
      lk_shift[lk_bit] = lk_shift[lk_bit] | d;
      if (lk_bit == 3'd7) begin
        rx_bytes[lk_byte] = lk_shift;
        lk_phase = PH_GAP;
      end else begin
        lk_bit = lk_bit + 3'd1;
        lk_phase = PH_LOW;
      end
    end else if (lk_phase == PH_GAP) begin
      lk_clk = 1'b1;
      lk_cmd = 1'b1;
      lk_bit = '0;
      lk_shift = '0;
      lk_phase = PH_LOW;
      lk_byte = lk_byte + 5'd1;
      if (lk_byte >= FRAME_LEN) begin
        lk_active = 1'b0;
        lk_byte = '0;
        done = 1'b1;
        dec_mode = rx_bytes[1];
        dec_buttons = {~rx_bytes[4], ~rx_bytes[3]};
        if (dec_mode == cfg_analog) begin
          dec_rh = {1'b0, rx_bytes[5]} - {1'b0, cfg_hctr};
          dec_rv = {1'b0, cfg_vctr} - {1'b0, rx_bytes[6]};
          dec_lh = {1'b0, rx_bytes[7]} - {1'b0, cfg_hctr};
          dec_lv = {1'b0, cfg_vctr} - {1'b0, rx_bytes[8]};
        end else begin
          dec_rh = {1'b0, rx_bytes[5]};
          dec_rv = {1'b0, rx_bytes[6]};
          dec_lh = {1'b0, rx_bytes[7]};
          dec_lv = {1'b0, rx_bytes[8]};
        end
      end
    end else begin
      // clock-low phase, also taken for the unused phase code
      case (lk_byte)
        5'd0: tx = START_BYTE;
        5'd1: tx = cfg_poll;
        default: tx = 8'h00;
      endcase
      lk_clk = 1'b0;
      lk_cmd = tx[lk_bit];
      lk_phase = PH_HIGH;
    end
    w.clk_l = lk_clk;
    w.cmd_l = lk_cmd;
    w.sel_n = !lk_active;
    w.busy = lk_active;
    w.done = done;
    w.mode = dec_mode;
    w.buttons = dec_buttons;
    w.rh = dec_rh;
    w.rv = dec_rv;
    w.lh = dec_lh;
    w.lv = dec_lv;
    expected_words.push_back(w);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_tick(input bit s, input bit d);
    int g;
    g = tx_idle_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= s;
    in_data_in <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(s, d);
    ticks_sent++;
  endtask

  // plan holds byte 0 in its low bits; only the sample ticks carry plan bits
  task automatic send_frame(input logic [FRAME_LEN*8-1:0] plan, input bit hold_start);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    for (int b = 0; b < FRAME_LEN; b++) begin
      for (int i = 0; i < 8; i++) begin
        send_tick(hold_start | 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_tick(hold_start | 1'($urandom_range(0, 1)), plan[b*8+i]);
      end
      send_tick(hold_start | 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] p, input logic [7:0] a,
                           input logic [7:0] h, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POLL_CMD;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= CFG_ANALOG_ID;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_H_CENTER;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_V_CENTER;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_poll = p;
    cfg_analog = a;
    cfg_hctr = h;
    cfg_vctr = v;
  endtask

  task automatic test_idle_lines();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // analog frame with default registers, start held high while busy, then an
  // immediate restart in raw mode and idle ticks that keep the lines high
  task automatic test_frames_default();
    send_frame({8'h7F, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h5A, 8'h73, 8'hFF}, 1'b1);
    send_frame({8'hFE, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h41, 8'h00}, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    write_cfg(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_frame({8'hFF, 8'h00, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h00}, 1'b0);
    wait_drained();
    write_cfg(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_frame({8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF}, 1'b0);
  endtask

  task automatic test_backpressure();
    logic [FRAME_LEN*8-1:0] plan;
    for (int b = 0; b < FRAME_LEN; b++) plan[b*8+:8] = rand_byte();
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_reqs++;
    send_frame(plan, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [FRAME_LEN*8-1:0] plan;
    int first;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        write_cfg(rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      for (int b = 0; b < FRAME_LEN; b++) plan[b*8+:8] = rand_byte();
      if ($urandom_range(0, 1) == 1) plan[15:8] = cfg_analog;
      send_frame(plan, 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int stall;
    int served;
    stall = 0;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served++;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_w.clk_l = out_clk_out;
      got_w.cmd_l = out_cmd_out;
      got_w.sel_n = out_select_n;
      got_w.busy = out_busy_res;
      got_w.done = out_frame_done;
      got_w.mode = out_mode_id;
      got_w.buttons = out_buttons;
      got_w.rh = out_right_horizontal;
      got_w.rv = out_right_vertical;
      got_w.lh = out_left_horizontal;
      got_w.lv = out_left_vertical;
      if (expected_words.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected output word at %0t", $realtime);
      end else begin
        exp_w = expected_words.pop_front();
        if (got_w.clk_l !== exp_w.clk_l || got_w.cmd_l !== exp_w.cmd_l ||
            got_w.sel_n !== exp_w.sel_n || got_w.busy !== exp_w.busy ||
            got_w.done !== exp_w.done || got_w.mode !== exp_w.mode ||
            got_w.buttons !== exp_w.buttons || got_w.rh !== exp_w.rh ||
            got_w.rv !== exp_w.rv || got_w.lh !== exp_w.lh || got_w.lv !== exp_w.lv) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp clk=%b cmd=%b sel_n=%b busy=%b done=%b mode=%h btn=%h %h %h %h %h",
                     exp_w.clk_l, exp_w.cmd_l, exp_w.sel_n, exp_w.busy, exp_w.done,
                     exp_w.mode, exp_w.buttons, exp_w.rh, exp_w.rv, exp_w.lh, exp_w.lv);
            $display("  got clk=%b cmd=%b sel_n=%b busy=%b done=%b mode=%h btn=%h %h %h %h %h",
                     got_w.clk_l, got_w.cmd_l, got_w.sel_n, got_w.busy, got_w.done,
                     got_w.mode, got_w.buttons, got_w.rh, got_w.rv, got_w.lh, got_w.lv);
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    fail_count = 0;
    mismatch_count = 0;
    ticks_sent = 0;
    hold_reqs = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    reset_model();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_POLL_CMD;
    cfg_wdata <= 8'h00;
    in_valid <= 1'b0;
    in_start_req <= 1'b0;
    in_data_in <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_lines();
    test_frames_default();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    if (expected_words.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
